// ----- src/assert_macros.svh -----
// Assertion macros used by the touch detector core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clock edge outside reset.
`define CTD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Property checked on every rising clock edge, reset included.
`define CTD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`else

`define CTD_ASSERT(lbl, prop)
`define CTD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- src/ctd_pkg.sv -----
// Package with widths, codes and divider request and response types of the touch detector.
`default_nettype none

package ctd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;

  localparam int MEAN_W      = 24;
  localparam int SUM_W       = 2 * MEAN_W;
  localparam int DEV_W       = 25;
  localparam int GAIN_W      = 16;
  localparam int PROD_W      = DEV_W + GAIN_W;
  localparam int DIV_W       = SUM_W;
  localparam int ROOT_W      = DIV_W / 2;
  localparam int DIV_STEP_W  = $clog2(DIV_W + 1);
  localparam int CFG_W       = 16;
  localparam int TIME_W      = 32;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_CALIB  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_OFFSET = 2'd1,
    REG_CAL_MS = 2'd2,
    REG_HOLD   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
    logic [DIV_W-1:0]      dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- src/ctd_div.sv -----
// Restoring serial divider, one quotient bit per cycle, shared by mean and variance.
`default_nettype none

module ctd_div
  import ctd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_STEP_W-1:0] cnt_q;
  logic [DIV_W-1:0]      dvd_q;
  logic [DIV_W-1:0]      quo_q;
  logic [COUNT_BITS-1:0] rem_q;
  logic [COUNT_BITS-1:0] dsr_q;

  logic [COUNT_BITS:0]   rem_sh;
  logic                  ge;
  logic [COUNT_BITS:0]   rem_next;

  always_comb begin
    rem_sh   = {rem_q, dvd_q[DIV_W-1]};
    ge       = rem_sh >= {1'b0, dsr_q};
    rem_next = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == DIV_STEP_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= rem_next[COUNT_BITS-1:0];
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ----- src/calibrated_touch_detector_core.sv -----
// Top level of the calibrated touch detector with its sequencer and statistics.
//
//   Channel   Direction  Handshake                    Payload
//   in        input      in_valid_i / in_stall_o      action, touch_sample, now_ms
//   out       output     out_valid_o / out_stall_i    touch, calibrating, mean, deviation
//   cfg       input      cfg_we_i                     cfg_index_i, cfg_data_i
//
// Calibrate and clear go to finish; samples outside calibration run the detection steps.
// A calibration sample runs the 24-step serial divide that updates the mean.
// The sample that closes the window adds a 48-step divide and a 24-step square root;
// both divides run on the shared divider.
// Reset clears all statistics and loads the register defaults; no clearing pass follows.
// A stalled result holds in the output register while the next transaction is accepted.
`default_nettype none
`include "assert_macros.svh"

module calibrated_touch_detector_core
  import ctd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        action_i,
  input  wire logic [15:0]       touch_sample_i,
  input  wire logic [TIME_W-1:0] now_ms_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   touch_detected_o,
  output logic                   calibrating_o,
  output logic [15:0]            baseline_mean_o,
  output logic [16:0]            deviation_level_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_START,
    ST_MEAN_WAIT,
    ST_SQ_MUL,
    ST_SQ_ADD,
    ST_VAR_START,
    ST_VAR_WAIT,
    ST_SQRT,
    ST_SET_DEV,
    ST_DET_MUL,
    ST_DET,
    ST_FINISH
  } state_e;

  state_e                 state_q;

  logic [GAIN_W-1:0]      gain_q;
  logic [CFG_W-1:0]       offset_q;
  logic [CFG_W-1:0]       cal_ms_q;
  logic [CFG_W-1:0]       hold_ms_q;

  logic [MEAN_W-1:0]      mean_q;
  logic [SUM_W-1:0]       sum_q;
  logic [COUNT_BITS-1:0]  mcnt_q;
  logic [COUNT_BITS-1:0]  vcnt_q;
  logic [DEV_W-1:0]       dev_q;
  logic                   incal_q;
  logic                   touch_q;
  logic [TIME_W-1:0]      wstart_q;
  logic [TIME_W-1:0]      lasthit_q;

  logic                   out_valid_q;
  logic                   out_touch_q;
  logic                   out_cal_q;
  logic [15:0]            out_mean_q;
  logic [16:0]            out_dev_q;

  logic [SAMPLE_BITS-1:0] x_q;
  logic [TIME_W-1:0]      now_q;
  logic                   half_q;
  logic                   end_q;
  logic [SUM_W-1:0]       sq_q;
  logic [PROD_W-1:0]      prod_q;
  logic [DIV_W-1:0]       sqv_q;
  logic [DIV_W-1:0]       sqres_q;
  logic [DIV_W-1:0]       sqbit_q;

  logic                   in_acc;
  logic [TIME_W-1:0]      elapsed;
  logic [MEAN_W-1:0]      xs;
  logic                   neg;
  logic [MEAN_W-1:0]      mag;
  logic [MEAN_W-1:0]      mean_q_div;
  logic [SUM_W:0]         sum_ext;
  logic [DIV_W-1:0]       sq_try;
  logic [PROD_W-1:0]      base;
  logic [PROD_W-1:0]      xcmp;
  logic [PROD_W-1:0]      diff;
  logic                   hit;
  logic                   hold_over;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign elapsed = now_ms_i - wstart_q;

  always_comb begin
    xs         = MEAN_W'({x_q, 8'b0});
    neg        = xs < mean_q;
    mag        = neg ? (mean_q - xs) : (xs - mean_q);
    mean_q_div = div_rsp.quotient[MEAN_W-1:0];
    sum_ext    = {1'b0, sum_q} + {1'b0, sq_q};
    sq_try     = sqres_q + sqbit_q;
    base       = PROD_W'({mean_q, 8'b0});
    xcmp       = PROD_W'({x_q, 16'b0});
    diff       = base - prod_q;
    hit        = (prod_q < base) && (xcmp < diff);
    hold_over  = (now_q - lasthit_q) >= TIME_W'(hold_ms_q);
  end

  always_comb begin
    div_req.start = (state_q == ST_MEAN_START) || (state_q == ST_VAR_START);
    if (state_q == ST_VAR_START) begin
      div_req.steps    = DIV_STEP_W'(DIV_W);
      div_req.dividend = sum_q;
    end else begin
      div_req.steps    = DIV_STEP_W'(MEAN_W);
      div_req.dividend = {mag, {(DIV_W - MEAN_W){1'b0}}};
    end
    div_req.divisor = (state_q == ST_VAR_START) ? vcnt_q : mcnt_q;
  end

  ctd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= GAIN_W'(256);
      offset_q    <= '0;
      cal_ms_q    <= CFG_W'(1000);
      hold_ms_q   <= CFG_W'(100);
      mean_q      <= '0;
      sum_q       <= '0;
      mcnt_q      <= '0;
      vcnt_q      <= '0;
      dev_q       <= '0;
      incal_q     <= 1'b0;
      touch_q     <= 1'b0;
      wstart_q    <= '0;
      lasthit_q   <= '0;
      out_valid_q <= 1'b0;
      out_touch_q <= 1'b0;
      out_cal_q   <= 1'b0;
      out_mean_q  <= '0;
      out_dev_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_GAIN:   gain_q    <= cfg_data_i;
          REG_OFFSET: offset_q  <= cfg_data_i;
          REG_CAL_MS: cal_ms_q  <= cfg_data_i;
          REG_HOLD:   hold_ms_q <= cfg_data_i;
          default:    ;
        endcase
      end
      if (out_valid_q && !out_stall_i && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (action_i)
              ACT_SAMPLE: begin
                if (incal_q) begin
                  if (mcnt_q != '1) begin
                    mcnt_q <= mcnt_q + 1'b1;
                  end
                  state_q <= ST_MEAN_START;
                end else begin
                  state_q <= ST_DET_MUL;
                end
              end
              ACT_CALIB: begin
                incal_q  <= 1'b1;
                wstart_q <= now_ms_i;
                mcnt_q   <= '0;
                vcnt_q   <= '0;
                mean_q   <= '0;
                sum_q    <= '0;
                dev_q    <= '0;
                state_q  <= ST_FINISH;
              end
              ACT_CLEAR: begin
                touch_q <= 1'b0;
                state_q <= ST_FINISH;
              end
              default: state_q <= ST_FINISH;
            endcase
          end
        end
        ST_MEAN_START: state_q <= ST_MEAN_WAIT;
        ST_MEAN_WAIT: begin
          if (div_rsp.done) begin
            mean_q  <= neg ? (mean_q - mean_q_div) : (mean_q + mean_q_div);
            state_q <= half_q ? ST_SQ_MUL : ST_FINISH;
          end
        end
        ST_SQ_MUL: state_q <= ST_SQ_ADD;
        ST_SQ_ADD: begin
          if (vcnt_q != '1) begin
            vcnt_q <= vcnt_q + 1'b1;
          end
          sum_q   <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
          state_q <= end_q ? ST_VAR_START : ST_FINISH;
        end
        ST_VAR_START: state_q <= ST_VAR_WAIT;
        ST_VAR_WAIT: begin
          if (div_rsp.done) begin
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqbit_q[0]) begin
            state_q <= ST_SET_DEV;
          end
        end
        ST_SET_DEV: begin
          dev_q   <= DEV_W'(sqres_q[ROOT_W-1:0]) + DEV_W'({offset_q, 8'b0});
          incal_q <= 1'b0;
          state_q <= ST_DET_MUL;
        end
        ST_DET_MUL: state_q <= ST_DET;
        ST_DET: begin
          if (hit) begin
            lasthit_q <= now_q;
            touch_q   <= 1'b1;
          end else if (hold_over) begin
            touch_q <= 1'b0;
          end
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_touch_q <= touch_q;
            out_cal_q   <= incal_q;
            out_mean_q  <= mean_q[MEAN_W-1:8];
            out_dev_q   <= dev_q[DEV_W-1:8];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= touch_sample_i[SAMPLE_BITS-1:0];
      now_q  <= now_ms_i;
      half_q <= elapsed > TIME_W'(cal_ms_q[CFG_W-1:1]);
      end_q  <= elapsed > TIME_W'(cal_ms_q);
    end
    if (state_q == ST_SQ_MUL) begin
      sq_q <= SUM_W'(mag) * SUM_W'(mag);
    end
    if (state_q == ST_DET_MUL) begin
      prod_q <= PROD_W'(dev_q) * PROD_W'(gain_q);
    end
    if (state_q == ST_VAR_WAIT) begin
      sqv_q   <= div_rsp.quotient;
      sqres_q <= '0;
      sqbit_q <= DIV_W'(1) << (DIV_W - 2);
    end else if (state_q == ST_SQRT) begin
      if (sqv_q >= sq_try) begin
        sqv_q   <= sqv_q - sq_try;
        sqres_q <= (sqres_q >> 1) + sqbit_q;
      end else begin
        sqres_q <= sqres_q >> 1;
      end
      sqbit_q <= sqbit_q >> 2;
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign touch_detected_o  = out_touch_q;
  assign calibrating_o     = out_cal_q;
  assign baseline_mean_o   = out_mean_q;
  assign deviation_level_o = out_dev_q;

  `CTD_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy)
  `CTD_ASSERT(a_mean_count, (state_q == ST_MEAN_START) |-> (mcnt_q != '0))
  `CTD_ASSERT(a_var_count, (state_q == ST_VAR_START) |-> (vcnt_q != '0))
  `CTD_ASSERT(a_root_fits, (state_q == ST_SET_DEV) |-> ((sqres_q >> ROOT_W) == '0))
  `CTD_ASSERT(a_finish_load,
    (state_q == ST_FINISH && !(out_valid_q && out_stall_i)) |=>
      (out_valid_q && state_q == ST_IDLE))

endmodule

`default_nettype wire

// ----- test/ctd_status_checker.sv -----
// Checker that predicts every touch detector status and compares it with the output channel.
`default_nettype none

module ctd_status_checker
  import ctd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_stall_i,
  input  wire logic [1:0]        action_i,
  input  wire logic [15:0]       touch_sample_i,
  input  wire logic [TIME_W-1:0] now_ms_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_stall_i,
  input  wire logic              touch_detected_i,
  input  wire logic              calibrating_i,
  input  wire logic [15:0]       baseline_mean_i,
  input  wire logic [16:0]       deviation_level_i,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  output int unsigned            due_count_o,
  output int unsigned            mismatch_count_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [63:0]           SUM_MAX   = (64'd1 << SUM_W) - 64'd1;

  typedef struct packed {
    logic        touch;
    logic        calib;
    logic [15:0] mean;
    logic [16:0] dev;
  } status_t;

  status_t status_due_q[$];
  status_t want;
  status_t next_status;
  int unsigned failures;

  logic [CFG_W-1:0]      gain;
  logic [CFG_W-1:0]      dev_offset;
  logic [CFG_W-1:0]      window_ms;
  logic [CFG_W-1:0]      hold_time;

  logic [MEAN_W-1:0]     mean_q;
  logic [SUM_W-1:0]      sq_sum;
  logic [COUNT_BITS-1:0] n_mean;
  logic [COUNT_BITS-1:0] n_var;
  logic [DEV_W-1:0]      dev_q;
  logic                  calibrating;
  logic                  touched;
  logic [TIME_W-1:0]     window_t0;
  logic [TIME_W-1:0]     last_hit_t;

  assign mismatch_count_o = failures;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  task automatic apply_touch_item(input logic [1:0] act, input logic [15:0] smp,
                                  input logic [TIME_W-1:0] t, output status_t st);
    logic [63:0] xs;
    logic [63:0] m;
    logic [63:0] delta;
    logic [63:0] total;
    logic [63:0] root;
    logic [63:0] prod;
    logic [63:0] base;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] since_hit;
    xs = {40'd0, smp, 8'd0};
    case (act)
      ACT_SAMPLE: begin
        if (calibrating) begin
          elapsed = t - window_t0;
          if (n_mean != COUNT_MAX) n_mean = n_mean + 1'b1;
          m = {40'd0, mean_q};
          if (xs >= m) m = m + (xs - m) / {40'd0, n_mean};
          else m = m - (m - xs) / {40'd0, n_mean};
          mean_q = m[MEAN_W-1:0];
          if (elapsed > (window_ms >> 1)) begin
            delta = (xs >= m) ? xs - m : m - xs;
            if (n_var != COUNT_MAX) n_var = n_var + 1'b1;
            total = {16'd0, sq_sum} + delta * delta;
            sq_sum = (total > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : total[SUM_W-1:0];
          end
          if (elapsed > window_ms) begin
            root = (n_var != 0) ? int_sqrt({16'd0, sq_sum} / {40'd0, n_var}) : 64'd0;
            total = root + ({48'd0, dev_offset} << 8);
            dev_q = total[DEV_W-1:0];
            calibrating = 1'b0;
          end
        end
        if (!calibrating) begin
          prod = {39'd0, dev_q} * {48'd0, gain};
          base = {40'd0, mean_q} << 8;
          if (prod < base && ({48'd0, smp} << 16) < base - prod) begin
            last_hit_t = t;
            touched = 1'b1;
          end else begin
            since_hit = t - last_hit_t;
            if (since_hit >= hold_time) touched = 1'b0;
          end
        end
      end
      ACT_CALIB: begin
        calibrating = 1'b1;
        window_t0 = t;
        n_mean = '0;
        n_var = '0;
        mean_q = '0;
        sq_sum = '0;
        dev_q = '0;
      end
      ACT_CLEAR: begin
        touched = 1'b0;
      end
      default: begin
      end
    endcase
    st = '{touched, calibrating, mean_q[MEAN_W-1:8], dev_q[DEV_W-1:8]};
  endtask

  task automatic compare_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain = 16'd256;
      dev_offset = 16'd0;
      window_ms = 16'd1000;
      hold_time = 16'd100;
      mean_q = '0;
      sq_sum = '0;
      n_mean = '0;
      n_var = '0;
      dev_q = '0;
      calibrating = 1'b0;
      touched = 1'b0;
      window_t0 = '0;
      last_hit_t = '0;
      status_due_q.delete();
      failures = 0;
      due_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_GAIN:   gain = cfg_data_i;
          REG_OFFSET: dev_offset = cfg_data_i;
          REG_CAL_MS: window_ms = cfg_data_i;
          REG_HOLD:   hold_time = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        apply_touch_item(action_i, touch_sample_i, now_ms_i, next_status);
        status_due_q.push_back(next_status);
      end
      if (out_valid_i && !out_stall_i) begin
        if (status_due_q.size() == 0) begin
          $error("status transaction arrived with no expected status pending");
          failures++;
        end else begin
          want = status_due_q.pop_front();
          compare_field("touch_detected", 32'(want.touch), 32'(touch_detected_i));
          compare_field("calibrating", 32'(want.calib), 32'(calibrating_i));
          compare_field("baseline_mean", 32'(want.mean), 32'(baseline_mean_i));
          compare_field("deviation_level", 32'(want.dev), 32'(deviation_level_i));
        end
      end
      due_count_o <= status_due_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_calibrated_touch_detector_core.sv -----
// Testbench top that drives touch samples and registers into the detector and gives the verdict.
`default_nettype none

module tb_calibrated_touch_detector_core;
  import ctd_pkg::*;

  localparam logic [1:0]  ACT_UNUSED  = 2'd3;
  localparam int unsigned ITEM_TARGET = 1750;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic              clk_i = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        action = ACT_SAMPLE;
  logic [15:0]       touch_sample = '0;
  logic [TIME_W-1:0] now_ms = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              touch_detected;
  logic              calibrating;
  logic [15:0]       baseline_mean;
  logic [16:0]       deviation_level;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = REG_GAIN;
  logic [CFG_W-1:0]  cfg_data = '0;

  int unsigned       due_count;
  int unsigned       mismatch_count;
  int unsigned       cycle_count;
  int unsigned       items_sent;
  bit                idle_on = 1'b1;
  int                cur_cal;
  int                cur_hold;
  logic [TIME_W-1:0] now_t;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  calibrated_touch_detector_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .action_i          (action),
    .touch_sample_i    (touch_sample),
    .now_ms_i          (now_ms),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .touch_detected_o  (touch_detected),
    .calibrating_o     (calibrating),
    .baseline_mean_o   (baseline_mean),
    .deviation_level_o (deviation_level),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  ctd_status_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .action_i          (action),
    .touch_sample_i    (touch_sample),
    .now_ms_i          (now_ms),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .touch_detected_i  (touch_detected),
    .calibrating_i     (calibrating),
    .baseline_mean_i   (baseline_mean),
    .deviation_level_i (deviation_level),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .due_count_o       (due_count),
    .mismatch_count_o  (mismatch_count)
  );

  always @(posedge clk_i) begin
    out_stall <= idle_on && ($urandom_range(99) < 25);
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("calibrated_touch_detector_core test failed");
    $finish;
  end

  task automatic send_item(input logic [1:0] act, input logic [15:0] smp,
                           input logic [TIME_W-1:0] t);
    while (idle_on && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action <= act;
    touch_sample <= smp;
    now_ms <= t;
    @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    @(posedge clk_i);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (due_count != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] g, input logic [15:0] o,
                              input logic [15:0] c, input logic [15:0] h);
    write_reg(REG_GAIN, g);
    write_reg(REG_OFFSET, o);
    write_reg(REG_CAL_MS, c);
    write_reg(REG_HOLD, h);
    cfg_we <= 1'b0;
    cur_cal = int'(c);
    cur_hold = int'(h);
  endtask

  function automatic logic [15:0] jitter(input int center, input int spread);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic run_session();
    int base_lvl;
    int spread;
    int step;
    int roll;
    logic [TIME_W-1:0] t0;
    base_lvl = $urandom_range(65535);
    case ($urandom_range(2))
      0: spread = 0;
      1: spread = $urandom_range(1, 30);
      default: spread = $urandom_range(100, 3000);
    endcase
    if ($urandom_range(9) == 0) now_t = 32'hFFFF_FFFF - $urandom_range(cur_cal);
    if ($urandom_range(9) != 0) begin
      t0 = now_t;
      send_item(ACT_CALIB, 16'($urandom), now_t);
      while (now_t - t0 <= cur_cal) begin
        now_t = now_t + $urandom_range(cur_cal / 3 + 1);
        roll = $urandom_range(99);
        if (roll < 3) begin
          send_item(ACT_CLEAR, 16'($urandom), now_t);
        end else if (roll < 5) begin
          send_item(ACT_UNUSED, 16'($urandom), now_t);
        end else if (roll < 7) begin
          send_item(ACT_CALIB, 16'($urandom), now_t);
          t0 = now_t;
        end else begin
          send_item(ACT_SAMPLE, jitter(base_lvl, spread), now_t);
        end
      end
    end
    repeat ($urandom_range(4, 16)) begin
      case ($urandom_range(3))
        0: step = $urandom_range(3);
        1: step = (cur_hold == 0) ? 0 : cur_hold - 1 + int'($urandom_range(2));
        default: step = $urandom_range(2 * cur_hold + 2);
      endcase
      now_t = now_t + step;
      roll = $urandom_range(99);
      if (roll < 5) begin
        send_item(ACT_CLEAR, 16'($urandom), now_t);
      end else if (roll < 7) begin
        send_item(ACT_UNUSED, 16'($urandom), now_t);
      end else if (roll < 55) begin
        send_item(ACT_SAMPLE, jitter(base_lvl, spread), now_t);
      end else if (roll < 85) begin
        send_item(ACT_SAMPLE, 16'(base_lvl - int'($urandom_range(base_lvl))), now_t);
      end else begin
        send_item(ACT_SAMPLE, 16'($urandom), now_t);
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] g;
    logic [15:0] o;
    logic [15:0] c;
    logic [15:0] h;
    items_sent = 0;
    cur_cal = 1000;
    cur_hold = 100;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Before any calibration nothing can be detected; an unknown action changes nothing.
    send_item(ACT_SAMPLE, 16'h0000, 32'h0000_0000);
    send_item(ACT_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(ACT_CLEAR, 16'h1234, 32'd5);
    send_item(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);

    // Shortest window straddling the time wrap, then a restart while touch is held.
    drain();
    program_regs(16'd256, 16'd0, 16'd2, 16'd0);
    send_item(ACT_CALIB, 16'h0000, 32'hFFFF_FFFE);
    send_item(ACT_SAMPLE, 16'd1000, 32'hFFFF_FFFE);
    send_item(ACT_SAMPLE, 16'd1200, 32'hFFFF_FFFF);
    send_item(ACT_SAMPLE, 16'd800, 32'd0);
    send_item(ACT_SAMPLE, 16'd1000, 32'd1);
    send_item(ACT_SAMPLE, 16'd0, 32'd2);
    send_item(ACT_CALIB, 16'hFFFF, 32'd3);
    send_item(ACT_SAMPLE, 16'hFFFF, 32'd3);
    send_item(ACT_SAMPLE, 16'h0000, 32'd7);
    send_item(ACT_CLEAR, 16'h0000, 32'd8);

    // Longest window and hold, largest offset, zero gain puts the threshold at the mean.
    drain();
    program_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(ACT_CALIB, 16'h0000, 32'd1000);
    send_item(ACT_SAMPLE, 16'd500, 32'd1000);
    send_item(ACT_SAMPLE, 16'd40000, 32'd66536);
    send_item(ACT_SAMPLE, 16'd100, 32'd66546);
    send_item(ACT_SAMPLE, 16'hFFFF, 32'd132080);
    send_item(ACT_SAMPLE, 16'hFFFF, 32'd132081);

    // Largest gain makes the threshold negative, so nothing is detected.
    drain();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(ACT_SAMPLE, 16'h0000, 32'd132090);

    now_t = 32'd200000;
    while (items_sent < ITEM_TARGET) begin
      drain();
      case ($urandom_range(4))
        0: g = 16'd0;
        1: g = 16'hFFFF;
        default: g = 16'($urandom_range(32, 768));
      endcase
      case ($urandom_range(7))
        0: o = 16'd0;
        1: o = 16'hFFFF;
        default: o = 16'($urandom_range(40));
      endcase
      case ($urandom_range(5))
        0: c = 16'd2;
        1: c = 16'hFFFF;
        2: c = 16'($urandom_range(2, 5000));
        default: c = 16'($urandom_range(2, 300));
      endcase
      case ($urandom_range(4))
        0: h = 16'd0;
        1: h = 16'hFFFF;
        default: h = 16'($urandom_range(300));
      endcase
      program_regs(g, o, c, h);
      repeat ($urandom_range(2, 5)) begin
        idle_on = !(items_sent >= 700 && items_sent < 1000);
        run_session();
      end
    end

    idle_on = 1'b1;
    drain();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && due_count == 0) begin
      $display("calibrated_touch_detector_core test passed");
    end else begin
      $display("calibrated_touch_detector_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/ctd_pkg.sv
src/ctd_div.sv
src/calibrated_touch_detector_core.sv
test/ctd_status_checker.sv
test/tb_calibrated_touch_detector_core.sv
